// ===== sv/mwd_pkg.sv =====
// Shared types and constants of the multitouch dejitter filter.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package mwd_pkg;

    // Field widths of one sample and one result.
    localparam int POS_W   = 15;
    localparam int PRESS_W = 16;
    localparam int THR_W   = 32;

    // History ring geometry.
    localparam int HIST_DEPTH = 8;
    localparam int SLOT_W     = 3;
    localparam int CNT_W      = 4;

    // Shared multiply-accumulate unit.
    localparam int OPD_W = 16;
    localparam int ACC_W = 2 * OPD_W;

    // Weight table: one row per history fill of two to eight samples.
    localparam int NROWS = 7;
    localparam int ROW_W = 3;
    localparam int WGT_W = 4;
    localparam int SH_W  = 3;

    localparam logic [THR_W-1:0] MOVE_THR_RESET = 32'd15;

    // Operation codes of an input item.
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_FRAME  = 1'b1;

    // Weights, newest sample first; each row sums to a power of two.
    localparam logic [WGT_W-1:0] WTAB [NROWS][HIST_DEPTH] = '{
        '{4'd5,  4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd8,  4'd5, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd6,  4'd4, 4'd3, 4'd3, 4'd0, 4'd0, 4'd0, 4'd0},
        '{4'd10, 4'd8, 4'd5, 4'd5, 4'd4, 4'd0, 4'd0, 4'd0},
        '{4'd9,  4'd7, 4'd5, 4'd4, 4'd4, 4'd3, 4'd0, 4'd0},
        '{4'd9,  4'd6, 4'd5, 4'd4, 4'd3, 4'd3, 4'd2, 4'd0},
        '{4'd9,  4'd5, 4'd4, 4'd3, 4'd3, 4'd3, 4'd3, 4'd2}
    };

    // Right shift that divides by the weight total of each row.
    localparam logic [SH_W-1:0] WSHIFT [NROWS] = '{
        3'd3, 3'd4, 3'd4, 3'd5, 3'd5, 3'd5, 3'd5
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DX,
        ST_DY,
        ST_CMP,
        ST_MX,
        ST_MY,
        ST_MP,
        ST_DONE
    } mwd_state_t;

    typedef enum logic [1:0] {
        ACC_X,
        ACC_Y,
        ACC_P
    } mwd_acc_sel_t;

    // Command to the shared multiply-accumulate unit.
    typedef struct packed {
        logic               en;
        logic               clr;
        mwd_acc_sel_t       sel;
        logic [OPD_W-1:0]   a;
        logic [OPD_W-1:0]   b;
    } mwd_mac_cmd_t;

    typedef struct packed {
        logic               operation;
        logic               tracked;
        logic               finger_index;
        logic [POS_W-1:0]   pos_x;
        logic [POS_W-1:0]   pos_y;
        logic [PRESS_W-1:0] press_in;
    } mwd_item_t;

    // One history entry.
    typedef struct packed {
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [PRESS_W-1:0] p;
    } mwd_entry_t;

    typedef struct packed {
        logic               finger;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [PRESS_W-1:0] p;
    } mwd_res_t;

endpackage

`default_nettype wire

// ===== sv/mwd_ifs.sv =====
// Valid/ready channel interfaces for samples, results and configuration.
// Depends on mwd_pkg for the field widths.
`default_nettype none

interface mwd_in_if import mwd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               operation;
    logic               tracked;
    logic               finger_index;
    logic [POS_W-1:0]   pos_x;
    logic [POS_W-1:0]   pos_y;
    logic [PRESS_W-1:0] press_in;

    modport source (
        output valid, operation, tracked, finger_index, pos_x, pos_y, press_in,
        input  ready
    );
    modport sink (
        input  valid, operation, tracked, finger_index, pos_x, pos_y, press_in,
        output ready
    );
endinterface

interface mwd_out_if import mwd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               finger_out;
    logic [POS_W-1:0]   smooth_x;
    logic [POS_W-1:0]   smooth_y;
    logic [PRESS_W-1:0] smooth_press;

    modport source (
        output valid, finger_out, smooth_x, smooth_y, smooth_press,
        input  ready
    );
    modport sink (
        input  valid, finger_out, smooth_x, smooth_y, smooth_press,
        output ready
    );
endinterface

interface mwd_cfg_if import mwd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [THR_W-1:0]   move_threshold;

    modport source (
        output valid, move_threshold,
        input  ready
    );
    modport sink (
        input  valid, move_threshold,
        output ready
    );
endinterface

`default_nettype wire

// ===== sv/multitouch_weighted_dejitter_core.sv =====
// Multitouch dejitter filter. A tracked sample is stored in its finger's
// eight-entry ring, and when the finger holds two to eight samples the result
// is their weighted average, newest weighted most; a single sample, an
// untracked sample, or one whose squared move from the previous sample exceeds
// move_threshold passes through unchanged, and a finger absent in the previous
// frame starts a new history. An end-of-frame item moves the presence flags
// and gives no result. All arithmetic goes through one multiply-accumulate
// unit: a filtered sample takes three products per history entry plus the
// two squares of the movement check, a sample that moved too far only the
// two squares, and a single or untracked sample none. No new item is taken
// until the previous sample's result has entered the output register, where
// it waits, so the next item is taken while it is still unread. The history
// needs no clearing after reset.
// Depends on mwd_pkg, the channel interfaces, mwd_seq, mwd_mac and mwd_hist.
`default_nettype none

module multitouch_weighted_dejitter_core
    import mwd_pkg::*;
#(
    parameter int FINGERS = 2
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    mwd_in_if.sink    sample,
    mwd_cfg_if.sink   cfg,
    mwd_out_if.source result
);

    localparam int ADDR_W = $clog2(FINGERS * HIST_DEPTH);

    logic [THR_W-1:0]  thr_reg;
    logic              out_valid_reg, out_valid_next;
    mwd_res_t          out_data_reg;

    mwd_item_t         item;
    logic              item_ready;
    mwd_mac_cmd_t      mac_cmd;
    logic [ACC_W-1:0]  acc_x;
    logic [ACC_W-1:0]  acc_y;
    logic [ACC_W-1:0]  acc_p;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    mwd_entry_t        wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    mwd_entry_t        rd_data;
    mwd_res_t          res;
    logic              res_push;
    logic              res_free;

    // Configuration register; a write transfer is always taken.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            thr_reg <= MOVE_THR_RESET;
        else if (cfg.valid)
            thr_reg <= cfg.move_threshold;
    end

    // Input channel into the sequencer.
    assign item = '{operation:    sample.operation,
                    tracked:      sample.tracked,
                    finger_index: sample.finger_index,
                    pos_x:        sample.pos_x,
                    pos_y:        sample.pos_y,
                    press_in:     sample.press_in};
    assign sample.ready = item_ready;

    mwd_seq #(
        .FINGERS (FINGERS)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .item           (item),
        .item_valid     (sample.valid),
        .item_ready     (item_ready),
        .move_threshold (thr_reg),
        .mac_cmd        (mac_cmd),
        .acc_x          (acc_x),
        .acc_y          (acc_y),
        .acc_p          (acc_p),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_data        (wr_data),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_data        (rd_data),
        .res            (res),
        .res_push       (res_push),
        .res_free       (res_free)
    );

    mwd_mac u_mac (
        .clk   (clk),
        .cmd   (mac_cmd),
        .acc_x (acc_x),
        .acc_y (acc_y),
        .acc_p (acc_p)
    );

    mwd_hist #(
        .FINGERS (FINGERS)
    ) u_hist (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Output register: takes a result when empty or being drained.
    assign res_free = !out_valid_reg || result.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_push)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_push)
            out_data_reg <= res;
    end

    assign result.valid        = out_valid_reg;
    assign result.finger_out   = out_data_reg.finger;
    assign result.smooth_x     = out_data_reg.x;
    assign result.smooth_y     = out_data_reg.y;
    assign result.smooth_press = out_data_reg.p;

endmodule

`default_nettype wire

// ===== sv/mwd_mac.sv =====
// Shared multiply-accumulate unit with three accumulators (x, y, pressure).
// Depends on mwd_pkg for the command type and widths.
`default_nettype none

module mwd_mac
    import mwd_pkg::*;
(
    input  wire logic             clk,
    input  wire mwd_mac_cmd_t     cmd,
    output logic [ACC_W-1:0]      acc_x,
    output logic [ACC_W-1:0]      acc_y,
    output logic [ACC_W-1:0]      acc_p
);

    logic [ACC_W-1:0] acc_x_reg;
    logic [ACC_W-1:0] acc_y_reg;
    logic [ACC_W-1:0] acc_p_reg;
    logic [ACC_W-1:0] acc_x_next;
    logic [ACC_W-1:0] acc_y_next;
    logic [ACC_W-1:0] acc_p_next;
    logic [ACC_W-1:0] prod;
    logic [ACC_W-1:0] addend;
    logic [ACC_W-1:0] sum;

    // One product per cycle, added to the selected accumulator or to zero.
    assign prod = cmd.a * cmd.b;

    always_comb
    begin
        case (cmd.sel)
            ACC_X:   addend = acc_x_reg;
            ACC_Y:   addend = acc_y_reg;
            ACC_P:   addend = acc_p_reg;
            default: addend = acc_x_reg;
        endcase
        sum = (cmd.clr ? '0 : addend) + prod;
    end

    // Write the sum back to the selected accumulator.
    always_comb
    begin
        acc_x_next = acc_x_reg;
        acc_y_next = acc_y_reg;
        acc_p_next = acc_p_reg;
        if (cmd.en)
        begin
            case (cmd.sel)
                ACC_X:   acc_x_next = sum;
                ACC_Y:   acc_y_next = sum;
                ACC_P:   acc_p_next = sum;
                default: acc_x_next = sum;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_x_reg <= acc_x_next;
        acc_y_reg <= acc_y_next;
        acc_p_reg <= acc_p_next;
    end

    assign acc_x = acc_x_reg;
    assign acc_y = acc_y_reg;
    assign acc_p = acc_p_reg;

endmodule

`default_nettype wire

// ===== sv/mwd_hist.sv =====
// History memory: one ring of samples per finger, one write and one read port.
// Depends on mwd_pkg for the entry type; read data is registered.
`default_nettype none

module mwd_hist
    import mwd_pkg::*;
#(
    parameter  int FINGERS = 2,
    localparam int DEPTH   = FINGERS * HIST_DEPTH,
    localparam int ADDR_W  = $clog2(DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire mwd_entry_t        wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output mwd_entry_t             rd_data
);

    mwd_entry_t hist_mem [DEPTH];
    mwd_entry_t rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            hist_mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= hist_mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/mwd_seq.sv =====
// Sequencer: per-finger ring state, movement check and weighted-sum loop.
// Depends on mwd_pkg; drives the shared MAC unit and the history memory.
`default_nettype none

module mwd_seq
    import mwd_pkg::*;
#(
    parameter  int FINGERS = 2,
    localparam int FIDX_W  = (FINGERS > 1) ? $clog2(FINGERS) : 1,
    localparam int ADDR_W  = $clog2(FINGERS * HIST_DEPTH)
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire mwd_item_t         item,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire logic [THR_W-1:0]  move_threshold,
    output mwd_mac_cmd_t           mac_cmd,
    input  wire logic [ACC_W-1:0]  acc_x,
    input  wire logic [ACC_W-1:0]  acc_y,
    input  wire logic [ACC_W-1:0]  acc_p,
    output logic                   wr_en,
    output logic [ADDR_W-1:0]      wr_addr,
    output mwd_entry_t             wr_data,
    output logic                   rd_en,
    output logic [ADDR_W-1:0]      rd_addr,
    input  wire mwd_entry_t        rd_data,
    output mwd_res_t               res,
    output logic                   res_push,
    input  wire logic              res_free
);

    mwd_state_t         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg  [FINGERS];
    logic [CNT_W-1:0]   cnt_next [FINGERS];
    logic [SLOT_W-1:0]  ring_reg  [FINGERS];
    logic [SLOT_W-1:0]  ring_next [FINGERS];
    logic [FINGERS-1:0] seen_last_reg, seen_last_next;
    logic [FINGERS-1:0] seen_this_reg, seen_this_next;

    logic [FIDX_W-1:0]  fidx_reg, fidx_next;
    logic               finger_reg, finger_next;
    logic [POS_W-1:0]   x_reg, x_next;
    logic [POS_W-1:0]   y_reg, y_next;
    logic [PRESS_W-1:0] p_reg, p_next;
    logic [SLOT_W-1:0]  cur_head_reg, cur_head_next;
    logic [CNT_W-1:0]   n_reg, n_next;
    logic [SLOT_W-1:0]  i_reg, i_next;
    logic               filt_reg, filt_next;

    logic               in_frame;
    logic               in_untracked;
    logic [FIDX_W-1:0]  in_fidx;
    logic [SLOT_W-1:0]  in_head;
    logic [CNT_W-1:0]   in_count;
    logic               move_reset;
    logic [CNT_W-1:0]   n_upd;
    logic               last_entry;
    logic [ROW_W-1:0]   row;
    logic [WGT_W-1:0]   weight;
    logic [SH_W-1:0]    shamt;
    logic [POS_W-1:0]   dx;
    logic [POS_W-1:0]   dy;
    logic               first_entry;
    logic [SLOT_W-1:0]  next_slot;
    logic [ACC_W-1:0]   sx;
    logic [ACC_W-1:0]   sy;
    logic [ACC_W-1:0]   sp;

    // Decode of the offered item.
    assign in_frame     = (item.operation == OP_FRAME);
    assign in_untracked = !item.tracked || (32'(item.finger_index) >= 32'(FINGERS));
    assign in_fidx      = FIDX_W'(item.finger_index);
    assign in_head      = ring_reg[in_fidx];
    assign in_count     = seen_last_reg[in_fidx] ? cnt_reg[in_fidx] : '0;

    // Movement check and fill update.
    assign move_reset = (acc_x > ACC_W'(move_threshold));
    assign n_upd      = (n_reg == CNT_W'(HIST_DEPTH)) ? n_reg : n_reg + CNT_W'(1);
    assign last_entry = ({1'b0, i_reg} == (n_reg - CNT_W'(1)));

    // Weight lookup for the current fill and entry.
    assign row         = ROW_W'(n_reg - CNT_W'(2));
    assign weight      = WTAB[row][i_reg];
    assign shamt       = WSHIFT[row];
    assign first_entry = (i_reg == '0);
    assign next_slot   = cur_head_reg - i_reg - SLOT_W'(1);

    // Absolute differences to the previous sample.
    assign dx = (x_reg >= rd_data.x) ? x_reg - rd_data.x : rd_data.x - x_reg;
    assign dy = (y_reg >= rd_data.y) ? y_reg - rd_data.y : rd_data.y - y_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (in_frame)
                        state_next = ST_IDLE;
                    else if (in_untracked || (in_count == '0))
                        state_next = ST_DONE;
                    else
                        state_next = ST_DX;
                end
            end
            ST_DX:   state_next = ST_DY;
            ST_DY:   state_next = ST_CMP;
            ST_CMP:  state_next = move_reset ? ST_DONE : ST_MX;
            ST_MX:   state_next = ST_MY;
            ST_MY:   state_next = ST_MP;
            ST_MP:   state_next = last_entry ? ST_DONE : ST_MX;
            ST_DONE:
            begin
                if (res_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs: handshake, memory access and MAC commands.
    always_comb
    begin
        item_ready  = 1'b0;
        res_push    = 1'b0;
        wr_en       = 1'b0;
        wr_addr     = ADDR_W'({in_fidx, in_head});
        wr_data     = '{x: item.pos_x, y: item.pos_y, p: item.press_in};
        rd_en       = 1'b0;
        rd_addr     = ADDR_W'({fidx_reg, next_slot});
        mac_cmd     = '{en: 1'b0, clr: 1'b0, sel: ACC_X, a: '0, b: '0};
        case (state_reg)
            ST_IDLE:
            begin
                item_ready = 1'b1;
                if (item_valid && !in_frame && !in_untracked)
                begin
                    wr_en   = 1'b1;
                    rd_en   = 1'b1;
                    rd_addr = ADDR_W'({in_fidx, in_head - SLOT_W'(1)});
                end
            end
            ST_DX:
            begin
                mac_cmd = '{en: 1'b1, clr: 1'b1, sel: ACC_X,
                            a: OPD_W'(dx), b: OPD_W'(dx)};
            end
            ST_DY:
            begin
                mac_cmd = '{en: 1'b1, clr: 1'b0, sel: ACC_X,
                            a: OPD_W'(dy), b: OPD_W'(dy)};
            end
            ST_MX:
            begin
                mac_cmd = '{en: 1'b1, clr: first_entry, sel: ACC_X,
                            a: OPD_W'(first_entry ? x_reg : rd_data.x),
                            b: OPD_W'(weight)};
            end
            ST_MY:
            begin
                mac_cmd = '{en: 1'b1, clr: first_entry, sel: ACC_Y,
                            a: OPD_W'(first_entry ? y_reg : rd_data.y),
                            b: OPD_W'(weight)};
            end
            ST_MP:
            begin
                mac_cmd = '{en: 1'b1, clr: first_entry, sel: ACC_P,
                            a: OPD_W'(first_entry ? p_reg : rd_data.p),
                            b: OPD_W'(weight)};
                rd_en   = 1'b1;
            end
            ST_DONE:
            begin
                res_push = res_free;
            end
            default:
            begin
                item_ready = 1'b0;
            end
        endcase
    end

    // Next values of the ring state and of the item being worked on.
    always_comb
    begin
        cnt_next       = cnt_reg;
        ring_next      = ring_reg;
        seen_last_next = seen_last_reg;
        seen_this_next = seen_this_reg;
        fidx_next      = fidx_reg;
        finger_next    = finger_reg;
        x_next         = x_reg;
        y_next         = y_reg;
        p_next         = p_reg;
        cur_head_next  = cur_head_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        filt_next      = filt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (in_frame)
                    begin
                        seen_last_next = seen_this_reg;
                        seen_this_next = '0;
                    end
                    else
                    begin
                        finger_next = item.finger_index;
                        x_next      = item.pos_x;
                        y_next      = item.pos_y;
                        p_next      = item.press_in;
                        filt_next   = 1'b0;
                        if (!in_untracked)
                        begin
                            fidx_next               = in_fidx;
                            cur_head_next           = in_head;
                            ring_next[in_fidx]      = in_head + SLOT_W'(1);
                            seen_this_next[in_fidx] = 1'b1;
                            n_next                  = in_count;
                            if (in_count == '0)
                                cnt_next[in_fidx] = CNT_W'(1);
                        end
                    end
                end
            end
            ST_CMP:
            begin
                if (move_reset)
                begin
                    cnt_next[fidx_reg] = CNT_W'(1);
                end
                else
                begin
                    cnt_next[fidx_reg] = n_upd;
                    n_next             = n_upd;
                    i_next             = '0;
                    filt_next          = 1'b1;
                end
            end
            ST_MP:
            begin
                if (!last_entry)
                    i_next = i_reg + SLOT_W'(1);
            end
            default:
            begin
                n_next = n_reg;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '{default: '0};
            ring_reg      <= '{default: '0};
            seen_last_reg <= '0;
            seen_this_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            ring_reg      <= ring_next;
            seen_last_reg <= seen_last_next;
            seen_this_reg <= seen_this_next;
        end
    end

    // Item registers.
    always_ff @(posedge clk)
    begin
        fidx_reg     <= fidx_next;
        finger_reg   <= finger_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        p_reg        <= p_next;
        cur_head_reg <= cur_head_next;
        n_reg        <= n_next;
        i_reg        <= i_next;
        filt_reg     <= filt_next;
    end

    // Result: the scaled weighted sums, or the raw sample.
    assign sx = acc_x >> shamt;
    assign sy = acc_y >> shamt;
    assign sp = acc_p >> shamt;

    always_comb
    begin
        res.finger = finger_reg;
        res.x      = filt_reg ? sx[POS_W-1:0]   : x_reg;
        res.y      = filt_reg ? sy[POS_W-1:0]   : y_reg;
        res.p      = filt_reg ? sp[PRESS_W-1:0] : p_reg;
    end

endmodule

`default_nettype wire
